FILE: sv/dlp_pkg.sv
// shared types and constants for the dhcp lease pool
`timescale 1ns / 1ps
`default_nettype none
package dlp_pkg;
   localparam int unsigned POOL_DEPTH_DEFAULT = 256;

   typedef enum logic [1:0] {
      OP_DISCOVER = 2'd0,
      OP_REQUEST  = 2'd1,
      OP_TICK     = 2'd2,
      OP_UNUSED   = 2'd3
   } op_type;

   localparam logic [2:0] MSG_OFFER = 3'd2;
   localparam logic [2:0] MSG_ACK   = 3'd5;
   localparam logic [2:0] MSG_NAK   = 3'd6;

   localparam logic [1:0] CSR_POOL_BASE = 2'd0;
   localparam logic [1:0] CSR_POOL_COUNT = 2'd1;
   localparam logic [1:0] CSR_LEASE_SECONDS = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LOOK,
      ST_DONE,
      ST_OUT
   } state_type;
endpackage
`default_nettype wire

FILE: sv/dhcp_lease_pool.sv
// dhcp lease pool: lease table in memory, serial first-free search
//
//   channel | ports                     | dir | content
//   req     | req_tvalid/tready/tdata   | in  | operation, mac, address, option, starve
//   rsp     | rsp_tvalid/tready/tdata   | out | reply type, address, mac, index
//   csr     | csr_we/csr_index/csr_wdata| in  | pool_base, pool_count, lease_seconds
//
// tick, unused operation or an item refused at the transfer: input ready again the next cycle.
// request: table read at the transfer, then look, done (compare) and out before the reply is valid.
// discover: one entry a cycle; the offer follows the out state after the first free entry
// of the v visited (at most POOL_DEPTH); a failed search frees the input after the last.
// reset clears the bound bits (flip-flops) and the time; mac and expiry are not cleared.
// a held result blocks new input until rsp_tready; ready returns the cycle after.
`timescale 1ns / 1ps
`default_nettype none
module dhcp_lease_pool #(
   parameter int unsigned POOL_DEPTH = dlp_pkg::POOL_DEPTH_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // operation[1:0], mac[49:2], requested_address[81:50],
   // has_requested[82], starve_flag[83], zero fill to 88
   input  wire logic [87:0]  req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // message_type[2:0], assigned_address[34:3], reply_mac[82:35],
   // entry_index[90:83], zero fill to 96
   output logic [95:0]       rsp_tdata,
   input  wire logic         csr_we,
   input  wire logic [1:0]   csr_index,
   input  wire logic [31:0]  csr_wdata
);
   import dlp_pkg::*;

   localparam int AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
   localparam int CW = $clog2(POOL_DEPTH + 1);

   logic [31:0] base_ff, lease_ff, time_ff;
   logic [8:0]  count_ff;
   logic [POOL_DEPTH-1:0] bound_ff;
   logic [47:0] mac_mem [POOL_DEPTH];
   logic [31:0] exp_mem [POOL_DEPTH];
   logic [47:0] rd_mac_ff;
   logic [31:0] rd_exp_ff;
   logic        rd_bound_ff;

   state_type state_ff, state_in;
   op_type    op_ff;
   logic [47:0] cmac_ff;
   logic [31:0] req_ff;
   logic        hreq_ff, starve_ff;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] n_ff;
   logic [2:0]  rtype_ff, rtype_in;
   logic [95:0] out_ff;
   logic        ovld_ff;

   // effective count
   logic [CW-1:0] n_eff;
   always_comb begin
      if ({23'd0, count_ff} > POOL_DEPTH) n_eff = CW'(POOL_DEPTH);
      else n_eff = CW'(count_ff);
   end

   logic [32:0] exp_sum;
   logic [31:0] new_exp;
   assign exp_sum = {1'b0, time_ff} + {1'b0, lease_ff};
   assign new_exp = exp_sum[32] ? 32'hFFFF_FFFF : exp_sum[31:0];

   logic [31:0] off;
   assign off = req_tdata[81:50] - base_ff;

   logic accept;
   assign req_tready = (state_ff == ST_IDLE) && !ovld_ff;
   assign accept = req_tvalid && req_tready;

   // registered entry read
   logic [AW-1:0] raddr;
   assign raddr = idx_in[AW-1:0];
   always_ff @(posedge clock) begin
      rd_mac_ff   <= mac_mem[raddr];
      rd_exp_ff   <= exp_mem[raddr];
      rd_bound_ff <= bound_ff[raddr];
   end

   logic active;
   assign active = rd_bound_ff && (rd_exp_ff >= time_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (op_type'(req_tdata[1:0]) == OP_REQUEST) begin
                  if (req_tdata[83] || !req_tdata[82] || off >= {{(32-CW){1'b0}}, n_eff})
                     state_in = ST_IDLE;
                  else state_in = ST_LOOK;
               end else if (op_type'(req_tdata[1:0]) == OP_DISCOVER && !req_tdata[83]
                            && n_eff != '0)
                  state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!active) state_in = ST_OUT;
            else if (idx_ff + 1'b1 >= n_ff) state_in = ST_IDLE;
         end
         ST_LOOK: state_in = ST_DONE;
         ST_DONE: state_in = ST_OUT;
         ST_OUT: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   logic do_write;
   always_comb begin
      idx_in   = idx_ff;
      rtype_in = rtype_ff;
      do_write = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               idx_in = '0;
               if (op_type'(req_tdata[1:0]) == OP_REQUEST) idx_in = off[CW-1:0];
            end
         end
         ST_SCAN: begin
            // data for idx_ff arrives this cycle; idx_in addresses the next
            if (!active) begin
               do_write = 1'b1;
               rtype_in = MSG_OFFER;
            end else if (idx_ff + 1'b1 < n_ff) begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (active && rd_mac_ff != cmac_ff) rtype_in = MSG_NAK;
            else begin
               rtype_in = MSG_ACK;
               do_write = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         mac_mem[idx_ff[AW-1:0]] <= cmac_ff;
         exp_mem[idx_ff[AW-1:0]] <= new_exp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         base_ff  <= '0;
         count_ff <= 9'd256;
         lease_ff <= 32'd3600;
         time_ff  <= '0;
         bound_ff <= '0;
         ovld_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               CSR_POOL_BASE:     base_ff  <= csr_wdata;
               CSR_POOL_COUNT:    count_ff <= csr_wdata[8:0];
               CSR_LEASE_SECONDS: lease_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (accept && op_type'(req_tdata[1:0]) == OP_TICK && time_ff != 32'hFFFF_FFFF)
            time_ff <= time_ff + 32'd1;
         if (do_write) bound_ff[idx_ff[AW-1:0]] <= 1'b1;
         if (state_ff == ST_OUT) ovld_ff <= 1'b1;
         else if (rsp_tready) ovld_ff <= 1'b0;
      end
   end

   logic [31:0] addr_out;
   assign addr_out = base_ff + {{(32-CW){1'b0}}, idx_ff};
   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      rtype_ff <= rtype_in;
      if (accept) begin
         op_ff     <= op_type'(req_tdata[1:0]);
         cmac_ff   <= req_tdata[49:2];
         req_ff    <= req_tdata[81:50];
         hreq_ff   <= req_tdata[82];
         starve_ff <= req_tdata[83];
         n_ff      <= n_eff;
      end
      if (state_ff == ST_OUT)
         out_ff <= {5'd0, 8'(idx_ff), cmac_ff, addr_out, rtype_ff};
   end

   assign rsp_tvalid = ovld_ff;
   assign rsp_tdata  = out_ff;

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == ST_IDLE) else $error("ready outside idle");
   a_out_type: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT |-> rtype_ff == MSG_OFFER || rtype_ff == MSG_ACK
      || rtype_ff == MSG_NAK) else $error("bad reply type");
   a_write_bound: assert property (@(posedge clock) disable iff (reset)
      do_write |=> bound_ff[$past(idx_ff[AW-1:0])]) else $error("bind lost");
   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> idx_ff < n_ff) else $error("scan past pool");
   a_unused: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |-> op_ff == OP_REQUEST && hreq_ff && !starve_ff
      && req_ff - base_ff < {{(32-CW){1'b0}}, n_ff}) else $error("bad lookup");
endmodule
`default_nettype wire

FILE: bench/dhcp_lease_pool_test.sv
// self-checking testbench for the dhcp lease pool
`timescale 1ns / 1ps
module dhcp_lease_pool_test;
   import dlp_pkg::*;

   localparam int DEPTH = 256;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic [2:0]  msg;
      logic [31:0] addr;
      logic [47:0] mac;
      logic [7:0]  idx;
   } reply_type;

   typedef struct {
      op_type      op;
      logic [47:0] mac;
      logic [31:0] addr;
      logic        has_req;
      logic        starve;
      logic        typed;     // expected reply given in the table
      logic        some;      // a reply is expected at all
      reply_type   reply;
   } row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [87:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [95:0] rsp_tdata;
   logic csr_we = 0;
   logic [1:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   dhcp_lease_pool i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // lease table shadow
   logic [31:0] base_q, count_q, lease_q, now_q;
   logic        bound_q [DEPTH];
   logic [47:0] owner_q [DEPTH];
   logic [31:0] expiry_q [DEPTH];

   reply_type pending_replies[$];
   int errors = 0;
   int replies_seen = 0;
   int items_sent = 0;
   int offers = 0, acks = 0, naks = 0;
   int idle_pct = 0, stall_pct = 0;
   int quiet_cycles = 0;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      errors++;
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
   endtask

   function automatic int unsigned effective_count();
      return count_q < DEPTH ? count_q : DEPTH;
   endfunction

   function automatic logic entry_live(int i);
      return bound_q[i] && expiry_q[i] >= now_q;
   endfunction

   function automatic logic [31:0] lease_end();
      logic [32:0] sum;
      sum = {1'b0, now_q} + {1'b0, lease_q};
      return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
   endfunction

   function automatic void grant(int i, logic [47:0] mac);
      bound_q[i] = 1;
      owner_q[i] = mac;
      expiry_q[i] = lease_end();
   endfunction

   // returns 1 and fills r when the item yields a reply
   function automatic logic lease_step(input op_type op, input logic [47:0] mac,
                                       input logic [31:0] addr, input logic has_req,
                                       input logic starve, output reply_type r);
      int unsigned n;
      logic [31:0] off;
      n = effective_count();
      r = '0;
      if (op == OP_TICK) begin
         if (now_q != 32'hFFFF_FFFF) now_q++;
         return 1'b0;
      end
      if (op == OP_UNUSED || starve) return 1'b0;
      if (op == OP_DISCOVER) begin
         for (int i = 0; i < n; i++) begin
            if (!entry_live(i)) begin
               grant(i, mac);
               r = '{MSG_OFFER, base_q + i, mac, i[7:0]};
               return 1'b1;
            end
         end
         return 1'b0;
      end
      if (!has_req) return 1'b0;
      off = addr - base_q;
      if (off >= n) return 1'b0;
      if (entry_live(int'(off)) && owner_q[off] != mac) begin
         r = '{MSG_NAK, addr, mac, off[7:0]};
         return 1'b1;
      end
      grant(int'(off), mac);
      r = '{MSG_ACK, addr, mac, off[7:0]};
      return 1'b1;
   endfunction

   task automatic send_item(input op_type op, input logic [47:0] mac,
                            input logic [31:0] addr, input logic has_req,
                            input logic starve, input logic typed, input logic some,
                            input reply_type typed_reply);
      reply_type r;
      logic got;
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {4'b0, starve, has_req, addr, mac, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      got = lease_step(op, mac, addr, has_req, starve, r);
      if (typed && (got != some || (some && r != typed_reply)))
         report_mismatch("table row", {61'b0, got, 2'b0}, {61'b0, some, 2'b0});
      if (got) pending_replies.insert(pending_replies.size(), r);
      items_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (pending_replies.size() != 0) @(posedge clock);
      // discover with no free entry may still be scanning
      repeat (DEPTH + 8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      case (idx)
         CSR_POOL_BASE: base_q = val;
         CSR_POOL_COUNT: count_q = val & 32'h1FF;
         default: lease_q = val;
      endcase
      @(posedge clock);
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset) begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
         if (rsp_tvalid && rsp_tready) begin
            reply_type got, want;
            got.msg  = rsp_tdata[2:0];
            got.addr = rsp_tdata[34:3];
            got.mac  = rsp_tdata[82:35];
            got.idx  = rsp_tdata[90:83];
            replies_seen++;
            if (pending_replies.size() == 0) begin
               report_mismatch("unexpected reply", rsp_tdata[63:0], '0);
            end else begin
               want = pending_replies.pop_front();
               if (got.msg != want.msg)
                  report_mismatch("message_type", 64'(got.msg), 64'(want.msg));
               if (got.addr != want.addr)
                  report_mismatch("assigned_address", 64'(got.addr), 64'(want.addr));
               if (got.mac != want.mac)
                  report_mismatch("reply_mac", 64'(got.mac), 64'(want.mac));
               if (got.idx != want.idx)
                  report_mismatch("entry_index", 64'(got.idx), 64'(want.idx));
               case (want.msg)
                  MSG_OFFER: offers++;
                  MSG_ACK: acks++;
                  default: naks++;
               endcase
            end
         end
      end
   end

   // watchdog on stalled progress
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset || csr_we)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("dhcp_lease_pool verification failed");
         $finish;
      end
   end

   // random traffic, biased so that binds, rebinds, naks and expiries all happen
   task automatic random_items(input int count, input logic [47:0] mac_pool[4]);
      int unsigned n;
      int kind;
      logic [47:0] mac;
      logic [31:0] addr;
      for (int k = 0; k < count; k++) begin
         n = effective_count();
         kind = $urandom_range(99);
         mac = ($urandom_range(9) == 0) ? 48'({$urandom, $urandom})
                                        : mac_pool[$urandom_range(3)];
         addr = base_q + $urandom_range(n == 0 ? 0 : n - 1);
         if ($urandom_range(9) == 0) addr = $urandom;
         if (kind < 35)
            send_item(OP_DISCOVER, mac, $urandom, 1'($urandom), $urandom_range(19) == 0,
                      0, 0, '0);
         else if (kind < 75)
            send_item(OP_REQUEST, mac, addr, $urandom_range(19) != 0,
                      $urandom_range(19) == 0, 0, 0, '0);
         else if (kind < 97)
            send_item(OP_TICK, 48'({$urandom, $urandom}), $urandom, 1'($urandom),
                      1'($urandom), 0, 0, '0);
         else
            send_item(OP_UNUSED, mac, addr, 1'($urandom), 1'($urandom), 0, 0, '0);
      end
   endtask

   initial begin
      row_type rows[$];
      logic [47:0] macs[4];
      reply_type none;
      none = '0;
      base_q = 0; count_q = 256; lease_q = 3600; now_q = 0;
      foreach (bound_q[i]) begin
         bound_q[i] = 0; owner_q[i] = 0; expiry_q[i] = 0;
      end
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // small pool, one-second lease: exercises exhaustion and expiry
      write_reg(CSR_POOL_BASE, 32'hFFFF_FFFE);
      write_reg(CSR_POOL_COUNT, 2);
      write_reg(CSR_LEASE_SECONDS, 1);
      rows = '{
         '{OP_DISCOVER, 48'hFFFF_FFFF_FFFF, 0, 0, 0, 1, 1,
           '{MSG_OFFER, 32'hFFFF_FFFE, 48'hFFFF_FFFF_FFFF, 8'd0}},
         '{OP_DISCOVER, 48'h0, 0, 0, 0, 1, 1, '{MSG_OFFER, 32'hFFFF_FFFF, 48'h0, 8'd1}},
         '{OP_DISCOVER, 48'h1, 0, 0, 0, 1, 0, none},                   // pool exhausted
         '{OP_REQUEST, 48'h1, 32'hFFFF_FFFE, 1, 0, 1, 1,
           '{MSG_NAK, 32'hFFFF_FFFE, 48'h1, 8'd0}},
         '{OP_REQUEST, 48'h0, 32'hFFFF_FFFF, 1, 0, 1, 1,
           '{MSG_ACK, 32'hFFFF_FFFF, 48'h0, 8'd1}},
         '{OP_REQUEST, 48'h1, 32'h0, 1, 0, 1, 0, none},                // wraps outside
         '{OP_REQUEST, 48'h1, 32'hFFFF_FFFE, 0, 0, 1, 0, none},        // no option
         '{OP_DISCOVER, 48'h2, 0, 0, 1, 1, 0, none},                   // starve
         '{OP_REQUEST, 48'h2, 32'hFFFF_FFFE, 1, 1, 1, 0, none},
         '{OP_UNUSED, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 1, 0, none},
         '{OP_TICK, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 1, 0, none},
         '{OP_TICK, 48'h0, 0, 0, 0, 1, 0, none},
         '{OP_DISCOVER, 48'h3, 0, 0, 0, 0, 0, none},                   // expired, reused
         '{OP_REQUEST, 48'h4, 32'hFFFF_FFFF, 1, 0, 0, 0, none}
      };
      foreach (rows[i])
         send_item(rows[i].op, rows[i].mac, rows[i].addr, rows[i].has_req,
                   rows[i].starve, rows[i].typed, rows[i].some, rows[i].reply);
      drain();

      // zero count and clamped count
      write_reg(CSR_POOL_COUNT, 0);
      send_item(OP_DISCOVER, 48'h5, 0, 0, 0, 1, 0, none);
      send_item(OP_REQUEST, 48'h5, 32'hFFFF_FFFE, 1, 0, 1, 0, none);
      drain();
      write_reg(CSR_POOL_COUNT, 9'h1FF);
      write_reg(CSR_POOL_BASE, 32'h0);
      write_reg(CSR_LEASE_SECONDS, 32'hFFFF_FFFF);      // saturating expiry
      send_item(OP_REQUEST, 48'h6, 32'd255, 1, 0, 1, 1, '{MSG_ACK, 32'd255, 48'h6, 8'd255});
      send_item(OP_REQUEST, 48'h6, 32'd256, 1, 0, 1, 0, none);
      drain();

      for (int ph = 0; ph < 5; ph++) begin
         for (int m = 0; m < 4; m++) macs[m] = 48'({$urandom, $urandom});
         case (ph)
            0: begin idle_pct = 0; stall_pct = 0; end
            1: begin idle_pct = 77; stall_pct = 0; end
            2: begin idle_pct = 0; stall_pct = 77; end
            3: begin idle_pct = 33; stall_pct = 33; end
            default: begin idle_pct = 0; stall_pct = 0; end
         endcase
         write_reg(CSR_POOL_BASE, (ph == 4) ? 32'hFFFF_FFF0 : $urandom);
         write_reg(CSR_POOL_COUNT, (ph == 2) ? 256 : $urandom_range(1, 24));
         write_reg(CSR_LEASE_SECONDS, (ph == 3) ? 32'd1 : $urandom_range(1, 40));
         random_items(370, macs);
         drain();
      end

      // current time runs into saturation only by ticks; push it near the top is too slow,
      // so a long lease checks saturation of expiry instead
      write_reg(CSR_LEASE_SECONDS, 32'hFFFF_FFFF);
      send_item(OP_DISCOVER, 48'hA5A5_5A5A_0F0F, 0, 0, 0, 0, 0, none);
      drain();

      $display("sent %0d items, %0d replies (%0d offers, %0d acks, %0d naks)",
               items_sent, replies_seen, offers, acks, naks);
      $display("covered exhaustion, expiry, wraparound, starve, clamped and empty pools");
      if (errors == 0 && pending_replies.size() == 0)
         $display("dhcp_lease_pool verification clean");
      else
         $display("dhcp_lease_pool verification failed");
      $finish;
   end
endmodule

FILE: filelist.f
sv/dlp_pkg.sv
sv/dhcp_lease_pool.sv
bench/dhcp_lease_pool_test.sv
